/* hw/rtl/asu_pkg.sv */
// ----------------------------------------------------------------------------
// asu_pkg
// Shared types, widths, register indexes and arithmetic helpers for the
// alpha split / unpremultiply pipeline.
// ----------------------------------------------------------------------------
package asu_pkg;

    // Pixel channel geometry
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int PIXEL_W  = 4 * CH_W;
    localparam int NUMER_W  = 2 * CH_W;

    // Divider: quotient bits resolved per pipeline stage
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = CH_W / BITS_PER_STAGE;

    // Coordinates, widths and offsets
    localparam int POS_W      = 12;
    localparam int SRC_WID_W  = 13;
    localparam int DUAL_WID_W = 14;
    localparam int BASE_W     = POS_W + DUAL_WID_W;
    localparam int OFS_W      = 28;

    // Stream payload widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 6 * PIXEL_W - 2 * (PIXEL_W - OFS_W);

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = DUAL_WID_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_DUAL_WIDTH    = 2'd1,
        REG_COLOR_ON_LEFT = 2'd2
    } cfg_reg_t;

    localparam logic [SRC_WID_W-1:0]  SOURCE_WIDTH_RST  = 13'd1;
    localparam logic [DUAL_WID_W-1:0] DUAL_WIDTH_RST    = 14'd2;
    localparam logic                  COLOR_ON_LEFT_RST = 1'b1;

    // Constant channel values
    localparam logic [CH_W-1:0]    CH_MAX     = 8'hFF;
    localparam logic [NUMER_W-1:0] ROUND_BIAS = 16'd127;

    typedef logic [CH_W-1:0] chan_t;

    // One restoring division step: shift in one numerator bit, subtract if
    // it fits. Result is {quotient bit, new remainder}.
    function automatic logic [CH_W:0] div_step(input chan_t rem, input logic nbit,
                                               input chan_t den);
        logic [CH_W:0] trial;
        logic [CH_W:0] diff;
        trial = {rem, nbit};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            return {1'b1, diff[CH_W-1:0]};
        end else begin
            return {1'b0, trial[CH_W-1:0]};
        end
    endfunction

    // floor(m / 255) for m below 65280, no divider needed
    function automatic chan_t div255(input logic [NUMER_W-1:0] m);
        logic [NUMER_W:0] t;
        t = {1'b0, m} + {{NUMER_W{1'b0}}, 1'b1} + {{(CH_W+1){1'b0}}, m[NUMER_W-1:CH_W]};
        return t[NUMER_W-1:CH_W];
    endfunction

endpackage

/* hw/rtl/asu_divider.sv */
// ----------------------------------------------------------------------------
// asu_divider
// Pipelined restoring divider, three channel lanes sharing one divisor.
// Quotient is known to fit in one channel byte.
// ----------------------------------------------------------------------------
module asu_divider (
    input  logic                                        aclk,
    input  logic [asu_pkg::DIV_STAGES-1:0]              stage_en,
    input  logic [asu_pkg::NUM_CH-1:0][asu_pkg::NUMER_W-1:0] numer,
    input  asu_pkg::chan_t                              divisor,
    output asu_pkg::chan_t [asu_pkg::NUM_CH-1:0]        quot
);

    localparam int NS  = asu_pkg::DIV_STAGES;
    localparam int NC  = asu_pkg::NUM_CH;
    localparam int CW  = asu_pkg::CH_W;
    localparam int NW  = asu_pkg::NUMER_W;

    asu_pkg::chan_t rem_reg  [NS][NC];
    asu_pkg::chan_t low_reg  [NS][NC];
    asu_pkg::chan_t quo_reg  [NS][NC];
    asu_pkg::chan_t den_reg  [NS];

    asu_pkg::chan_t rem_src  [NS][NC];
    asu_pkg::chan_t low_src  [NS][NC];
    asu_pkg::chan_t quo_src  [NS][NC];
    asu_pkg::chan_t den_src  [NS];

    asu_pkg::chan_t rem_next [NS][NC];
    asu_pkg::chan_t low_next [NS][NC];
    asu_pkg::chan_t quo_next [NS][NC];

    // Stage inputs: first stage starts with the high numerator byte as
    // partial remainder (it is below the divisor when the result fits)
    always_comb begin
        den_src[0] = divisor;
        for (int s = 1; s < NS; s++) begin
            den_src[s] = den_reg[s-1];
        end
        for (int c = 0; c < NC; c++) begin
            rem_src[0][c] = numer[c][NW-1:CW];
            low_src[0][c] = numer[c][CW-1:0];
            quo_src[0][c] = '0;
            for (int s = 1; s < NS; s++) begin
                rem_src[s][c] = rem_reg[s-1][c];
                low_src[s][c] = low_reg[s-1][c];
                quo_src[s][c] = quo_reg[s-1][c];
            end
        end
    end

    // Division steps of each stage
    always_comb begin
        logic [CW:0]    step;
        asu_pkg::chan_t r;
        asu_pkg::chan_t l;
        asu_pkg::chan_t q;
        for (int s = 0; s < NS; s++) begin
            for (int c = 0; c < NC; c++) begin
                r = rem_src[s][c];
                l = low_src[s][c];
                q = quo_src[s][c];
                for (int b = 0; b < asu_pkg::BITS_PER_STAGE; b++) begin
                    step = asu_pkg::div_step(r, l[CW-1], den_src[s]);
                    r    = step[CW-1:0];
                    q    = {q[CW-2:0], step[CW]};
                    l    = {l[CW-2:0], 1'b0};
                end
                rem_next[s][c] = r;
                low_next[s][c] = l;
                quo_next[s][c] = q;
            end
        end
    end

    // Stage registers
    always_ff @(posedge aclk) begin
        for (int s = 0; s < NS; s++) begin
            if (stage_en[s]) begin
                den_reg[s] <= den_src[s];
                for (int c = 0; c < NC; c++) begin
                    rem_reg[s][c] <= rem_next[s][c];
                    low_reg[s][c] <= low_next[s][c];
                    quo_reg[s][c] <= quo_next[s][c];
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            quot[c] = quo_reg[NS-1][c];
        end
    end

endmodule

/* hw/rtl/asu_black.sv */
// ----------------------------------------------------------------------------
// asu_black
// Composites the unpremultiplied color over black: round(c * a / 255),
// one multiply stage and one constant-divide stage.
// ----------------------------------------------------------------------------
module asu_black (
    input  logic                                 aclk,
    input  logic                                 en_mul,
    input  logic                                 en_out,
    input  asu_pkg::chan_t [asu_pkg::NUM_CH-1:0] color,
    input  asu_pkg::chan_t                       alpha,
    output asu_pkg::chan_t [asu_pkg::NUM_CH-1:0] black
);

    localparam int NC = asu_pkg::NUM_CH;
    localparam int CW = asu_pkg::CH_W;
    localparam int NW = asu_pkg::NUMER_W;

    logic [NW-1:0]  prod_reg  [NC];
    asu_pkg::chan_t black_reg [NC];

    // Product plus rounding bias; no ties since 255 is odd
    always_ff @(posedge aclk) begin
        for (int c = 0; c < NC; c++) begin
            if (en_mul) begin
                prod_reg[c] <= {{CW{1'b0}}, color[c]} * {{CW{1'b0}}, alpha}
                               + asu_pkg::ROUND_BIAS;
            end
            if (en_out) begin
                black_reg[c] <= asu_pkg::div255(prod_reg[c]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            black[c] = black_reg[c];
        end
    end

endmodule

/* hw/rtl/alpha_split_unpremultiply.sv */
// ----------------------------------------------------------------------------
// alpha_split_unpremultiply
// Unpremultiplies one RGBA pixel, splits it into color and gray-alpha halves
// of a dual image, composites both over black and gives their byte offsets.
// ----------------------------------------------------------------------------
// Accepts one item per clock when the output side does not stall and
// returns one result item for each, in order. The channel divider resolves
// two quotient bits in each of its four stages; one register stage in front
// of it forms the numerators and the row product, and two after it do the
// over-black multiply and the divide by 255. Every stage holds its item
// under stall and bubbles close up, so input is taken while a result waits
// at the output as long as some stage is empty.
// Configuration writes are taken in any cycle (cfg_ready is always high) and
// must only be made while the pipeline is empty.
// ----------------------------------------------------------------------------
module alpha_split_unpremultiply (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: pos_x[11:0], pos_y[23:12], src_pixel[55:24]
    input  logic [asu_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: left_dual[31:0], right_dual[63:32], left_black[95:64],
    //        right_black[127:96], left_offset[155:128], right_offset[183:156]
    output logic [asu_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [asu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [asu_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int NC       = asu_pkg::NUM_CH;
    localparam int CW       = asu_pkg::CH_W;
    localparam int NW       = asu_pkg::NUMER_W;
    localparam int PW       = asu_pkg::POS_W;
    localparam int BW       = asu_pkg::BASE_W;
    localparam int OW       = asu_pkg::OFS_W;
    localparam int DIV_LAST = asu_pkg::DIV_STAGES + 1;
    localparam int STG_MUL  = asu_pkg::DIV_STAGES + 2;
    localparam int LAST     = asu_pkg::DIV_STAGES + 3;

    // Configuration registers
    logic [asu_pkg::SRC_WID_W-1:0]  src_width_reg;
    logic [asu_pkg::DUAL_WID_W-1:0] dual_width_reg;
    logic                           color_left_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= asu_pkg::SOURCE_WIDTH_RST;
            dual_width_reg <= asu_pkg::DUAL_WIDTH_RST;
            color_left_reg <= asu_pkg::COLOR_ON_LEFT_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == asu_pkg::REG_SOURCE_WIDTH) begin
                src_width_reg <= cfg_data[asu_pkg::SRC_WID_W-1:0];
            end
            if (cfg_index == asu_pkg::REG_DUAL_WIDTH) begin
                dual_width_reg <= cfg_data[asu_pkg::DUAL_WID_W-1:0];
            end
            if (cfg_index == asu_pkg::REG_COLOR_ON_LEFT) begin
                color_left_reg <= cfg_data[0];
            end
        end
    end

    // Pipeline flow control: a stage loads when it is empty or drains
    logic [LAST:1]   v_reg;
    logic [LAST:1]   v_next;
    logic [LAST:1]   v_in;
    logic [LAST+1:1] en;

    assign v_in = {v_reg[LAST-1:1], s_tvalid};

    always_comb begin
        en[LAST+1] = m_tready;
        for (int k = LAST; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
        for (int k = 1; k <= LAST; k++) begin
            v_next[k] = en[k] ? v_in[k] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = v_reg[LAST];

    // Input unpacking
    logic [PW-1:0]               in_x;
    logic [PW-1:0]               in_y;
    logic [asu_pkg::PIXEL_W-1:0] in_px;
    asu_pkg::chan_t              in_a;

    assign in_x  = s_tdata[PW-1:0];
    assign in_y  = s_tdata[2*PW-1:PW];
    assign in_px = s_tdata[2*PW+asu_pkg::PIXEL_W-1:2*PW];
    assign in_a  = in_px[4*CW-1:3*CW];

    // Stage registers
    logic [NC-1:0][NW-1:0] numer_reg;
    logic [PW-1:0]         x_reg;
    logic [BW-1:0]         prod_reg;
    logic [BW-1:0]         base_reg;
    asu_pkg::chan_t        alpha_reg [1:LAST];
    logic                  azero_reg [1:DIV_LAST];
    logic [NC-1:0]         sat_reg   [1:DIV_LAST];
    logic [OW-1:0]         lofs_reg  [3:LAST];
    logic [OW-1:0]         rofs_reg  [3:LAST];
    asu_pkg::chan_t [NC-1:0] u_mul_reg;
    asu_pkg::chan_t [NC-1:0] u_out_reg;

    asu_pkg::chan_t [NC-1:0] quot;
    asu_pkg::chan_t [NC-1:0] u_sel;
    asu_pkg::chan_t [NC-1:0] black_ch;

    always_ff @(posedge aclk) begin
        // Numerators c*255, saturation flags, row product
        if (en[1]) begin
            alpha_reg[1] <= in_a;
            azero_reg[1] <= (in_a == '0);
            x_reg        <= in_x;
            prod_reg     <= BW'(in_y) * BW'(dual_width_reg);
            for (int c = 0; c < NC; c++) begin
                numer_reg[c] <= {in_px[c*CW +: CW], {CW{1'b0}}}
                                - {{CW{1'b0}}, in_px[c*CW +: CW]};
                sat_reg[1][c] <= (in_px[c*CW +: CW] >= in_a);
            end
        end
        // Offsets
        if (en[2]) begin
            base_reg <= prod_reg + BW'(x_reg);
        end
        if (en[3]) begin
            lofs_reg[3] <= {base_reg, 2'b00};
            rofs_reg[3] <= {base_reg + BW'(src_width_reg), 2'b00};
        end
        for (int k = 4; k <= LAST; k++) begin
            if (en[k]) begin
                lofs_reg[k] <= lofs_reg[k-1];
                rofs_reg[k] <= rofs_reg[k-1];
            end
        end
        // Side data riding along the divider
        for (int k = 2; k <= LAST; k++) begin
            if (en[k]) begin
                alpha_reg[k] <= alpha_reg[k-1];
            end
        end
        for (int k = 2; k <= DIV_LAST; k++) begin
            if (en[k]) begin
                azero_reg[k] <= azero_reg[k-1];
                sat_reg[k]   <= sat_reg[k-1];
            end
        end
        if (en[STG_MUL]) begin
            u_mul_reg <= u_sel;
        end
        if (en[LAST]) begin
            u_out_reg <= u_mul_reg;
        end
    end

    asu_divider u_div (
        .aclk     (aclk),
        .stage_en (en[DIV_LAST:2]),
        .numer    (numer_reg),
        .divisor  (alpha_reg[1]),
        .quot     (quot)
    );

    // Unpremultiplied channel: zero alpha gives zero, color at or above
    // alpha saturates
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            if (azero_reg[DIV_LAST]) begin
                u_sel[c] = '0;
            end else if (sat_reg[DIV_LAST][c]) begin
                u_sel[c] = asu_pkg::CH_MAX;
            end else begin
                u_sel[c] = quot[c];
            end
        end
    end

    asu_black u_black (
        .aclk   (aclk),
        .en_mul (en[STG_MUL]),
        .en_out (en[LAST]),
        .color  (u_sel),
        .alpha  (alpha_reg[DIV_LAST]),
        .black  (black_ch)
    );

    // Output assembly; the gray half over black equals the gray half
    logic [asu_pkg::PIXEL_W-1:0] color_px;
    logic [asu_pkg::PIXEL_W-1:0] gray_px;
    logic [asu_pkg::PIXEL_W-1:0] color_blk;
    logic [asu_pkg::PIXEL_W-1:0] left_dual;
    logic [asu_pkg::PIXEL_W-1:0] right_dual;
    logic [asu_pkg::PIXEL_W-1:0] left_black;
    logic [asu_pkg::PIXEL_W-1:0] right_black;

    assign color_px  = {alpha_reg[LAST], u_out_reg[2], u_out_reg[1], u_out_reg[0]};
    assign gray_px   = {asu_pkg::CH_MAX, alpha_reg[LAST], alpha_reg[LAST], alpha_reg[LAST]};
    assign color_blk = {asu_pkg::CH_MAX, black_ch[2], black_ch[1], black_ch[0]};

    assign left_dual   = color_left_reg ? color_px  : gray_px;
    assign right_dual  = color_left_reg ? gray_px   : color_px;
    assign left_black  = color_left_reg ? color_blk : gray_px;
    assign right_black = color_left_reg ? gray_px   : color_blk;

    assign m_tdata = {rofs_reg[LAST], lofs_reg[LAST], right_black, left_black,
                      right_dual, left_dual};

endmodule

/* test/alpha_split_unpremultiply_checker.sv */
// ----------------------------------------------------------------------------
// alpha_split_unpremultiply checker
// Watches the pixel, result and register channels of the block. Each pixel
// taken in is turned into its expected dual-image pair, which is queued and
// compared field by field with the next result item that leaves the block.
// ----------------------------------------------------------------------------
module alpha_split_unpremultiply_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: pos_x[11:0], pos_y[23:12], src_pixel[55:24]
    input  logic [asu_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // tdata: left_dual[31:0], right_dual[63:32], left_black[95:64],
    //        right_black[127:96], left_offset[155:128], right_offset[183:156]
    input  logic [asu_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [asu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [asu_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  fail_count,
    output int                                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import asu_pkg::*;

    // One result item, left_dual in the lowest bits
    typedef struct packed {
        logic [OFS_W-1:0]   right_offset;
        logic [OFS_W-1:0]   left_offset;
        logic [PIXEL_W-1:0] right_black;
        logic [PIXEL_W-1:0] left_black;
        logic [PIXEL_W-1:0] right_dual;
        logic [PIXEL_W-1:0] left_dual;
    } dual_pair_t;

    // Shadow copy of the registers
    logic [SRC_WID_W-1:0]  source_width_q;
    logic [DUAL_WID_W-1:0] dual_width_q;
    logic                  color_left_q;

    dual_pair_t pending_pairs[$];
    dual_pair_t want;
    dual_pair_t got;

    // Exact integer unpremultiply of one channel, saturating at full scale
    function automatic chan_t unpremul_chan(input chan_t c, input chan_t a);
        int unsigned q;
        if (a == 8'd0) return 8'd0;
        if (a == CH_MAX) return c;
        q = (32'(c) * 32'd255) / 32'(a);
        return (q > 32'd255) ? CH_MAX : q[7:0];
    endfunction

    // round(c * al / 255); 255 is odd so no tie can come up
    function automatic chan_t darken_chan(input chan_t c, input chan_t al);
        int unsigned n;
        n = 32'(c) * 32'(al);
        return 8'((2 * n + 32'd255) / 32'd510);
    endfunction

    // Pixel composited over black, alpha forced opaque
    function automatic logic [PIXEL_W-1:0] over_black(input logic [PIXEL_W-1:0] px);
        chan_t al;
        al = px[31:24];
        return {CH_MAX, darken_chan(px[23:16], al), darken_chan(px[15:8], al),
                darken_chan(px[7:0], al)};
    endfunction

    // Expected result item for one source pixel under the current registers
    function automatic dual_pair_t predict_dual(input logic [POS_W-1:0] x,
                                                input logic [POS_W-1:0] y,
                                                input logic [PIXEL_W-1:0] px);
        chan_t              a;
        logic [PIXEL_W-1:0] color;
        logic [PIXEL_W-1:0] gray;
        logic [63:0]        base;
        dual_pair_t         r;
        a     = px[31:24];
        color = {a, unpremul_chan(px[23:16], a), unpremul_chan(px[15:8], a),
                 unpremul_chan(px[7:0], a)};
        gray  = {CH_MAX, a, a, a};
        r.left_dual    = color_left_q ? color : gray;
        r.right_dual   = color_left_q ? gray : color;
        r.left_black   = over_black(r.left_dual);
        r.right_black  = over_black(r.right_dual);
        base           = 64'(y) * 64'(dual_width_q) + 64'(x);
        r.left_offset  = 28'(base * 64'd4);
        r.right_offset = 28'((base + 64'(source_width_q)) * 64'd4);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%h, actual 0x%h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            source_width_q = SOURCE_WIDTH_RST;
            dual_width_q   = DUAL_WIDTH_RST;
            color_left_q   = COLOR_ON_LEFT_RST;
            pending_pairs.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  source_width_q = cfg_data[SRC_WID_W-1:0];
                    REG_DUAL_WIDTH:    dual_width_q   = cfg_data[DUAL_WID_W-1:0];
                    REG_COLOR_ON_LEFT: color_left_q   = cfg_data[0];
                    default: ;
                endcase
            end
            // result items against the oldest expectation
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_pairs.size() == 0) begin
                    $error("result item with no pixel outstanding: 0x%h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_pairs.pop_front();
                    check_field("left_dual", want.left_dual, got.left_dual);
                    check_field("right_dual", want.right_dual, got.right_dual);
                    check_field("left_black", want.left_black, got.left_black);
                    check_field("right_black", want.right_black, got.right_black);
                    check_field("left_offset", 32'(want.left_offset), 32'(got.left_offset));
                    check_field("right_offset", 32'(want.right_offset),
                                32'(got.right_offset));
                end
            end
            // pixels taken in
            if (s_tvalid && s_tready) begin
                pending_pairs.push_back(predict_dual(s_tdata[11:0], s_tdata[23:12],
                                                     s_tdata[55:24]));
            end
        end
        pending_count = pending_pairs.size();
    end

endmodule

/* test/alpha_split_unpremultiply_tb.sv */
// ----------------------------------------------------------------------------
// alpha_split_unpremultiply testbench
// Streams directed and random premultiplied pixels through the block under
// several register settings and idling patterns on both stream sides; the
// checker predicts every result item and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module alpha_split_unpremultiply_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asu_pkg::*;

    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 8;
    localparam int CYCLE_LIMIT     = 200000;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]     s_tdata   = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;

    int fail_count;
    int pending_count;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;

    alpha_split_unpremultiply u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    alpha_split_unpremultiply_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one pixel item; returns at the edge that takes it
    task automatic push_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic [PIXEL_W-1:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {px, y, x};
        @(negedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
            @(negedge aclk);
        end
        @(posedge aclk);
    endtask

    // Random pixel, mostly well-formed premultiplied data
    task automatic push_random;
        logic [7:0]       a;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        int               sel;
        sel = $urandom_range(9);
        a   = 8'($urandom);
        r   = 8'($urandom);
        g   = 8'($urandom);
        b   = 8'($urandom);
        case (sel)
            0: a = 8'd0;
            1: a = CH_MAX;
            2: a = 8'($urandom_range(1, 3));
            3, 4, 5, 6: begin
                a = 8'($urandom_range(1, 254));
                r = 8'($urandom_range(0, a));
                g = 8'($urandom_range(0, a));
                b = 8'($urandom_range(0, a));
            end
            default: ;
        endcase
        x = 12'($urandom);
        y = 12'($urandom);
        if ($urandom_range(15) == 0) x = ($urandom_range(1) != 0) ? 12'hFFF : 12'h000;
        if ($urandom_range(15) == 0) y = ($urandom_range(1) != 0) ? 12'hFFF : 12'h000;
        push_pixel(x, y, {a, b, g, r});
    endtask

    // Stop sending and wait until every result item has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
            @(negedge aclk);
        end
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] src_w,
                                  input logic [CFG_DATA_W-1:0] dual_w,
                                  input logic [CFG_DATA_W-1:0] col_left);
        write_reg(REG_SOURCE_WIDTH, src_w);
        write_reg(REG_DUAL_WIDTH, dual_w);
        write_reg(REG_COLOR_ON_LEFT, col_left);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] src_w;
        logic [CFG_DATA_W-1:0] dual_w;
        logic [CFG_DATA_W-1:0] col_left;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 29;
        recv_idle_pct = 63;

        // Directed pixels under the reset register values
        push_pixel(12'h000, 12'h000, 32'h0000_0000);
        push_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
        push_pixel(12'h001, 12'h000, 32'h00FF_FFFF);   // transparent, color dropped
        push_pixel(12'h000, 12'h001, 32'hFF12_3456);   // opaque, color passes
        push_pixel(12'h123, 12'h456, 32'h0102_0001);   // alpha one saturates
        push_pixel(12'h7FF, 12'h800, 32'h0101_0101);
        push_pixel(12'h800, 12'h7FF, 32'h8040_4040);   // floor of a half
        push_pixel(12'hAAA, 12'h555, 32'h1020_2020);   // color above alpha
        push_pixel(12'h555, 12'hAAA, 32'h8080_8080);   // color equal to alpha
        push_pixel(12'hFFF, 12'h000, 32'hFEFD_FDFD);
        push_pixel(12'h000, 12'hFFF, 32'h0201_0001);
        push_pixel(12'h00F, 12'hF00, 32'hAA55_AA55);
        push_pixel(12'hF00, 12'h00F, 32'h55AA_55AA);
        push_pixel(12'h3C3, 12'hC3C, 32'h7F7F_7E01);
        push_pixel(12'hC3C, 12'h3C3, 32'h0000_00FF);
        push_pixel(12'h001, 12'h001, 32'h01FF_0000);
        push_pixel(12'hFFE, 12'hFFE, 32'hFE00_FEFF);
        push_pixel(12'h0FF, 12'hF0F, 32'h7F80_FF7F);
        drain;

        // Random pixels over extreme and random register settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin src_w = 14'd4096;  dual_w = 14'd8192;  col_left = 14'd1;      end
                1: begin src_w = 14'd1;     dual_w = 14'd2;     col_left = 14'd0;      end
                2: begin src_w = 14'h3FFF;  dual_w = 14'h3FFF;  col_left = 14'h3FFE;   end
                3: begin src_w = 14'd0;     dual_w = 14'd0;     col_left = 14'h3FFF;   end
                default: begin
                    src_w    = 14'($urandom_range(1, 4096));
                    dual_w   = 14'($urandom_range(2, 8192));
                    col_left = 14'($urandom);
                end
            endcase
            if (ph == 3) begin
                send_idle_pct = 63;
                recv_idle_pct = 29;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_settings(src_w, dual_w, col_left);
            repeat (ITEMS_PER_PHASE) push_random;
            drain;
        end

        repeat (20) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
